FILE: sv/pid_pkg.sv
// ============================================================================
// pid_pkg
// Shared types and constants for the fixed-point PID controller: register
// indexes, field widths, register reset values and the drive saturation bounds.
// ============================================================================
package pid_pkg;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Register widths
    localparam int GAIN_W  = 16;
    localparam int DB_W    = 16;
    localparam int LIM_W   = 31;

    // Accumulator register and drive widths
    localparam int ESUM_W  = 32;
    localparam int DRIVE_W = 32;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_SPEED_MODE     = 3'd3,
        CFG_DEAD_BAND      = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5
    } cfg_addr_t;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 16'sd2560;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST    = 16'sd614;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = 16'sd0;
    localparam logic                     SPEED_MODE_RST = 1'b1;
    localparam logic [DB_W-1:0]          DEAD_BAND_RST = 16'd128;
    localparam logic [LIM_W-1:0]         INT_LIMIT_RST = 31'd2560000;

    // Saturation bounds of the 32-bit signed range
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

endpackage

FILE: sv/pid_with_deadband_and_clamp_unit.sv
// ============================================================================
// pid_with_deadband_and_clamp_unit
// Positional PID step with deadband and integral clamp in speed mode, and
// saturation of the accumulated error and of the drive in 32 bits.
// ============================================================================
//
//  channel | ports                          | beat contents (low bits first)
//  --------+--------------------------------+---------------------------------
//  input   | s_tvalid s_tready s_tdata      | setpoint, measured, zero pad
//  result  | m_tvalid m_tready m_tdata/tuser| tdata: drive; tuser: drive_saturated
//  config  | cfg_valid cfg_ready cfg_index  | cfg_data: register value
//
//  One beat is accepted per cycle while s_tready is high; each beat passes the
//  input register, the error/integral stage, the product registers and the
//  result register before m_tvalid rises. The integral update (add and clamp)
//  is the only loop. Reset (aresetn low, synchronous) clears the state, the
//  pipeline and loads the register defaults. A stall on m_tready fills the
//  bubbles first and then drops s_tready; cfg_ready is always high.
// ============================================================================
module pid_with_deadband_and_clamp_unit #(
    parameter int VALUE_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // setpoint [VALUE_WIDTH-1:0], measured [2*VALUE_WIDTH-1:VALUE_WIDTH], zero pad
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // drive [31:0]
    output logic [pid_pkg::DRIVE_W-1:0]           m_tdata,
    // drive_saturated [0]
    output logic                                  m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pid_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pid_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int EW     = VALUE_WIDTH + 1;
    localparam int DIFF_W = EW + 1;
    localparam int CMP_W  = ((EW > pid_pkg::DB_W + 1) ? EW : pid_pkg::DB_W + 1) + 1;
    localparam int SUM_W  = ((EW > pid_pkg::ESUM_W) ? EW : pid_pkg::ESUM_W) + 1;
    localparam int PP_W   = pid_pkg::GAIN_W + EW;
    localparam int PI_W   = pid_pkg::GAIN_W + pid_pkg::ESUM_W;
    localparam int PD_W   = pid_pkg::GAIN_W + DIFF_W;
    localparam int ACC_W  = ((PD_W > PI_W) ? PD_W : PI_W) + 2;

    // Configuration registers
    logic signed [pid_pkg::GAIN_W-1:0] gain_p_reg;
    logic signed [pid_pkg::GAIN_W-1:0] gain_i_reg;
    logic signed [pid_pkg::GAIN_W-1:0] gain_d_reg;
    logic                              speed_mode_reg;
    logic [pid_pkg::DB_W-1:0]          dead_band_reg;
    logic [pid_pkg::LIM_W-1:0]         integral_limit_reg;

    // Controller state (also the payload of the error stage)
    logic signed [pid_pkg::ESUM_W-1:0] error_sum_reg;
    logic signed [EW-1:0]              error_prev_reg;
    logic signed [pid_pkg::ESUM_W-1:0] error_sum_next;
    logic signed [EW-1:0]              error_prev_next;

    // Pipeline registers
    logic                              v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [VALUE_WIDTH-1:0]     setpoint_reg;
    logic signed [VALUE_WIDTH-1:0]     measured_reg;
    logic signed [DIFF_W-1:0]          diff_reg;
    logic signed [DIFF_W-1:0]          diff_next;
    logic signed [PP_W-1:0]            prod_p_reg;
    logic signed [PI_W-1:0]            prod_i_reg;
    logic signed [PD_W-1:0]            prod_d_reg;
    logic [pid_pkg::DRIVE_W-1:0]       drive_reg;
    logic [pid_pkg::DRIVE_W-1:0]       drive_next;
    logic                              sat_reg;
    logic                              sat_next;

    // Handshake between stages
    logic rdy0, rdy1, rdy2, rdy3;
    logic load0, load1, load2, load3;

    // Error stage signals
    logic signed [EW-1:0]     err_raw;
    logic signed [EW-1:0]     err_db;
    logic signed [CMP_W-1:0]  err_cmp;
    logic signed [CMP_W-1:0]  db_cmp;
    logic                     in_band;
    logic signed [SUM_W-1:0]  sum_wide;
    logic signed [SUM_W-1:0]  lim_pos;
    logic signed [SUM_W-1:0]  lim_neg;
    logic signed [SUM_W-1:0]  sum_max;
    logic signed [SUM_W-1:0]  sum_min;
    logic signed [SUM_W-1:0]  sum_sel;

    // Result stage signals
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_shr;
    logic signed [ACC_W-1:0]  acc_max;
    logic signed [ACC_W-1:0]  acc_min;

    // Bubble-collapsing ready chain
    assign rdy3  = !v3_reg || m_tready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign rdy0  = !v0_reg || rdy1;
    assign load0 = s_tvalid && rdy0;
    assign load1 = v0_reg && rdy1;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;

    assign s_tready  = rdy0;
    assign m_tvalid  = v3_reg;
    assign m_tdata   = drive_reg;
    assign m_tuser   = sat_reg;
    assign cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= pid_pkg::GAIN_P_RST;
            gain_i_reg         <= pid_pkg::GAIN_I_RST;
            gain_d_reg         <= pid_pkg::GAIN_D_RST;
            speed_mode_reg     <= pid_pkg::SPEED_MODE_RST;
            dead_band_reg      <= pid_pkg::DEAD_BAND_RST;
            integral_limit_reg <= pid_pkg::INT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pid_pkg::CFG_GAIN_P:         gain_p_reg <= cfg_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::CFG_GAIN_I:         gain_i_reg <= cfg_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::CFG_GAIN_D:         gain_d_reg <= cfg_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::CFG_SPEED_MODE:     speed_mode_reg <= cfg_data[0];
                pid_pkg::CFG_DEAD_BAND:      dead_band_reg <= cfg_data[pid_pkg::DB_W-1:0];
                pid_pkg::CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[pid_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Error, deadband, integral update and clamp
    always_comb begin
        err_raw = {setpoint_reg[VALUE_WIDTH-1], setpoint_reg}
                - {measured_reg[VALUE_WIDTH-1], measured_reg};
        err_cmp = {{(CMP_W-EW){err_raw[EW-1]}}, err_raw};
        db_cmp  = {{(CMP_W-pid_pkg::DB_W){1'b0}}, dead_band_reg};
        in_band = (err_cmp < db_cmp) && (err_cmp > -db_cmp);
        err_db  = (speed_mode_reg && in_band) ? '0 : err_raw;

        sum_wide = {{(SUM_W-pid_pkg::ESUM_W){error_sum_reg[pid_pkg::ESUM_W-1]}}, error_sum_reg}
                 + {{(SUM_W-EW){err_db[EW-1]}}, err_db};
        lim_pos  = {{(SUM_W-pid_pkg::LIM_W){1'b0}}, integral_limit_reg};
        lim_neg  = -lim_pos;
        sum_max  = {{(SUM_W-pid_pkg::DRIVE_W){1'b0}}, pid_pkg::DRIVE_MAX};
        sum_min  = {{(SUM_W-pid_pkg::DRIVE_W){1'b1}}, pid_pkg::DRIVE_MIN};

        if (speed_mode_reg) begin
            if (sum_wide >= lim_pos) begin
                sum_sel = lim_pos;
            end else if (sum_wide < lim_neg) begin
                sum_sel = lim_neg;
            end else begin
                sum_sel = sum_wide;
            end
        end else begin
            if (sum_wide > sum_max) begin
                sum_sel = sum_max;
            end else if (sum_wide < sum_min) begin
                sum_sel = sum_min;
            end else begin
                sum_sel = sum_wide;
            end
        end

        error_sum_next  = sum_sel[pid_pkg::ESUM_W-1:0];
        error_prev_next = err_db;
        diff_next       = {err_db[EW-1], err_db} - {error_prev_reg[EW-1], error_prev_reg};
    end

    // Sum products, shift back to the value format and saturate
    always_comb begin
        acc = {{(ACC_W-PP_W){prod_p_reg[PP_W-1]}}, prod_p_reg}
            + {{(ACC_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg}
            + {{(ACC_W-PD_W){prod_d_reg[PD_W-1]}}, prod_d_reg};
        acc_shr = acc >>> FRAC_BITS;
        acc_max = {{(ACC_W-pid_pkg::DRIVE_W){1'b0}}, pid_pkg::DRIVE_MAX};
        acc_min = {{(ACC_W-pid_pkg::DRIVE_W){1'b1}}, pid_pkg::DRIVE_MIN};
        if (acc_shr > acc_max) begin
            drive_next = pid_pkg::DRIVE_MAX;
            sat_next   = 1'b1;
        end else if (acc_shr < acc_min) begin
            drive_next = pid_pkg::DRIVE_MIN;
            sat_next   = 1'b1;
        end else begin
            drive_next = acc_shr[pid_pkg::DRIVE_W-1:0];
            sat_next   = 1'b0;
        end
    end

    // Advance stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= load0 || (v0_reg && !rdy1);
            v1_reg <= load1 || (v1_reg && !rdy2);
            v2_reg <= load2 || (v2_reg && !rdy3);
            v3_reg <= load3 || (v3_reg && !m_tready);
        end
    end

    // Update controller state as an item enters the error stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            error_prev_reg <= '0;
        end else if (load1) begin
            error_sum_reg  <= error_sum_next;
            error_prev_reg <= error_prev_next;
        end
    end

    // Payload registers of each stage
    always_ff @(posedge aclk) begin
        if (load0) begin
            setpoint_reg <= s_tdata[VALUE_WIDTH-1:0];
            measured_reg <= s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
        end
        if (load1) begin
            diff_reg <= diff_next;
        end
        if (load2) begin
            prod_p_reg <= gain_p_reg * error_prev_reg;
            prod_i_reg <= gain_i_reg * error_sum_reg;
            prod_d_reg <= gain_d_reg * diff_reg;
        end
        if (load3) begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A saturated result carries one of the two range bounds
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == pid_pkg::DRIVE_MAX ||
                                   m_tdata == pid_pkg::DRIVE_MIN))
        else $error("saturated drive is not a range bound");

    // In speed mode the accumulated error stays within the clamp
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (load1 && speed_mode_reg) |=>
            ($signed({error_sum_reg[pid_pkg::ESUM_W-1], error_sum_reg})
                 <= $signed({2'b00, $past(integral_limit_reg)}) &&
             $signed({error_sum_reg[pid_pkg::ESUM_W-1], error_sum_reg})
                 >= -$signed({2'b00, $past(integral_limit_reg)})))
        else $error("accumulated error outside the integral limit");

    // Input stalls only when every stage is full and the result is held
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v0_reg && v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    // The deadband leaves no error smaller than its width in speed mode
    a_dead_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (load1 && speed_mode_reg && in_band) |=> (error_prev_reg == '0))
        else $error("error inside the deadband was not zeroed");
`endif

endmodule
